### src/lgs_pkg.sv
// Shared types, constants and helpers for the life generation block.
// No dependencies; imported by every module of the block.
package lgs_pkg;

  // Fixed widths of the request and result fields
  localparam int ROW_W   = 32;
  localparam int IDX_W   = 5;
  localparam int DIM_W   = 6;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Default grid limit for the top level parameter
  localparam int MAX_DIM_DEFAULT = 32;

  // Request command codes
  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Register index codes (paddr bit 2)
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  // Reset value of both size registers
  localparam logic [DIM_W-1:0] DIM_RESET = 6'd16;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             alive;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_cells;
    logic             last_row;
  } result_t;

  // Strobes from the sequencer to the grid memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } mem_ctrl_t;

  // Clamp a raw size register to the range 1..limit
  function automatic logic [DIM_W-1:0] used_dim(input logic [DIM_W-1:0] raw,
                                                input logic [DIM_W-1:0] limit);
    logic [DIM_W-1:0] v;
    v = raw;
    if (v == '0) begin
      v = 6'd1;
    end
    if (v > limit) begin
      v = limit;
    end
    return v;
  endfunction

endpackage

### src/life_generation_step.sv
// Game of life generation block: top level with APB registers and sequencer.
// Uses lgs_pkg, lgs_grid_mem and lgs_row_rule.
//
// A write request, once taken, keeps busy high while it reads, then modifies
// and writes back one row. An advance request keeps busy high while the grid
// memory's single read port streams one old row per cycle into a three-row
// window and the one row evaluation unit turns out one new row per cycle,
// written back in place. Results follow one per cycle, row 0 first, each on
// result for exactly one cycle while result_valid is high; the receiver
// cannot stall them, so it must take every one. Writing grid_rows or
// grid_cols clears the grid at once, with no clearing pass.
module life_generation_step #(
  parameter int MAX_DIM = lgs_pkg::MAX_DIM_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lgs_pkg::request_t          request,
  output logic                       result_valid,
  output lgs_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lgs_pkg::ADDR_W-1:0] paddr,
  input  logic [lgs_pkg::DATA_W-1:0] pwdata,
  output logic [lgs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import lgs_pkg::*;

  localparam int DIM_LIMIT = (MAX_DIM < ROW_W) ? MAX_DIM : ROW_W;
  localparam int AW        = $clog2(DIM_LIMIT);
  localparam logic [DIM_W-1:0] LIMIT_V = DIM_W'(DIM_LIMIT);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_WR_READ = 2'd1;
  localparam logic [1:0] ST_WR_MOD  = 2'd2;
  localparam logic [1:0] ST_ADV     = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  request_t         req;
  logic [DIM_W-1:0] cnt;
  logic [ROW_W-1:0] prev1;
  logic [ROW_W-1:0] prev2;
  logic [DIM_W-1:0] grid_rows;
  logic [DIM_W-1:0] grid_cols;

  logic [DIM_W-1:0] rows_used;
  logic [DIM_W-1:0] cols_used;
  logic [ROW_W-1:0] cmask;
  logic             cfg_wr;
  logic             accept;
  mem_ctrl_t        mem_ctrl;
  logic [AW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_data;
  logic [AW-1:0]    rd_addr;
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] below;
  logic [ROW_W-1:0] next_row;
  logic [DIM_W-1:0] out_row;
  logic             adv_emit;
  logic             adv_end;
  logic             wr_in_range;
  logic [ROW_W-1:0] col_bit;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_GRID_COLS) ? DATA_W'(grid_cols) : DATA_W'(grid_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= DIM_RESET;
      grid_cols <= DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GRID_ROWS) begin
        grid_rows <= pwdata[DIM_W-1:0];
      end else begin
        grid_cols <= pwdata[DIM_W-1:0];
      end
    end
  end

  // Effective grid size and column mask
  assign rows_used = used_dim(grid_rows, LIMIT_V);
  assign cols_used = used_dim(grid_cols, LIMIT_V);

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      cmask[c] = (DIM_W'(c) < cols_used);
    end
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Advance window: the row after the current one is dead past the last row
  assign below    = (cnt == rows_used + 6'd1) ? '0 : (rd_data & cmask);
  assign adv_emit = (state == ST_ADV) && (cnt >= 6'd2);
  assign adv_end  = (cnt == rows_used + 6'd1);
  assign out_row  = cnt - 6'd2;

  lgs_row_rule u_rule (
    .above    (prev2),
    .here     (prev1),
    .below    (below),
    .cmask    (cmask),
    .next_row (next_row)
  );

  // Single-cell write target
  assign wr_in_range = ({1'b0, req.row} < rows_used) && ({1'b0, req.col} < cols_used);
  assign col_bit     = ROW_W'(1) << req.col;

  // Drive the grid memory
  always_comb begin
    mem_ctrl       = '0;
    mem_ctrl.clear = cfg_wr;
    rd_addr        = cnt[AW-1:0];
    wr_addr        = out_row[AW-1:0];
    wr_data        = next_row;
    unique case (state)
      ST_IDLE: begin
      end
      ST_WR_READ: begin
        mem_ctrl.rd_en = 1'b1;
        rd_addr        = req.row[AW-1:0];
      end
      ST_WR_MOD: begin
        mem_ctrl.wr_en = wr_in_range;
        wr_addr        = req.row[AW-1:0];
        wr_data        = req.alive ? (rd_data | col_bit) : (rd_data & ~col_bit);
      end
      ST_ADV: begin
        mem_ctrl.rd_en = (cnt < rows_used);
        mem_ctrl.wr_en = adv_emit;
      end
      default: begin
      end
    endcase
  end

  lgs_grid_mem #(
    .DEPTH (DIM_LIMIT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (mem_ctrl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (request.cmd == CMD_ADVANCE) ? ST_ADV : ST_WR_READ;
        end
      end
      ST_WR_READ: state_next = ST_WR_MOD;
      ST_WR_MOD:  state_next = ST_IDLE;
      ST_ADV: begin
        if (adv_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request, step the row counter and shift the window
  always_ff @(posedge clk) begin
    if (accept) begin
      req   <= request;
      cnt   <= '0;
      prev1 <= '0;
      prev2 <= '0;
    end else if (state == ST_ADV) begin
      cnt <= cnt + 6'd1;
      if (cnt != '0) begin
        prev2 <= prev1;
        prev1 <= below;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= adv_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_emit) begin
      result.row_index <= out_row[IDX_W-1:0];
      result.row_cells <= next_row;
      result.last_row  <= adv_end;
    end
  end

endmodule

### src/lgs_grid_mem.sv
// Cell grid storage: one row mask per entry, one write and one read port.
// Per-row valid bits make reset and resize clear the grid at once. Uses lgs_pkg.
module lgs_grid_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lgs_pkg::mem_ctrl_t      ctrl,
  input  logic [AW-1:0]           wr_addr,
  input  logic [lgs_pkg::ROW_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [lgs_pkg::ROW_W-1:0] rd_data
);
  import lgs_pkg::*;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [ROW_W-1:0] rd_q;
  logic             rd_valid;

  // Write port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track which rows hold written data
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  // A row never written reads as all dead
  assign rd_data = rd_valid ? rd_q : '0;

endmodule

### src/lgs_row_rule.sv
// Row evaluation unit: applies B3/S23 to one row from a three-row window.
// Purely combinational; uses lgs_pkg.
module lgs_row_rule (
  input  logic [lgs_pkg::ROW_W-1:0] above,
  input  logic [lgs_pkg::ROW_W-1:0] here,
  input  logic [lgs_pkg::ROW_W-1:0] below,
  input  logic [lgs_pkg::ROW_W-1:0] cmask,
  output logic [lgs_pkg::ROW_W-1:0] next_row
);
  import lgs_pkg::*;

  logic [ROW_W+1:0] a_p;
  logic [ROW_W+1:0] h_p;
  logic [ROW_W+1:0] b_p;
  logic [ROW_W-1:0] res;

  // Pad with dead cells past both edges
  assign a_p = {1'b0, above & cmask, 1'b0};
  assign h_p = {1'b0, here & cmask, 1'b0};
  assign b_p = {1'b0, below & cmask, 1'b0};

  // Count neighbours per column and apply birth/survival
  always_comb begin
    logic [3:0] n;
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
        + 4'(h_p[c]) + 4'(h_p[c+2])
        + 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
      res[c] = (n == 4'd3) || ((n == 4'd2) && h_p[c+1]);
    end
  end

  // Columns beyond the grid stay dead
  assign next_row = res & cmask;

endmodule
